// ===== rtl/bsag_pkg.sv =====
// Shared types and constants for the broadcast source address generator.
// No dependencies; every other file of the block imports this package.
package bsag_pkg;

   localparam int IDX_W        = 32;
   localparam int ADDR_W       = 48;
   localparam int CFG_W        = 64;
   localparam int RANK_W       = 4;
   localparam int EB_W         = 5;
   localparam int SLOT_BITS    = 16;
   localparam int SLOTS_PER_W  = 4;
   localparam int DIV_STEPS    = 4;
   localparam int QUEUE_DEPTH  = 4;
   localparam int DEF_MAX_RANK = 8;
   localparam int DEF_DIM_BITS = 16;

   typedef enum logic [2:0] {
      CSR_OUTPUT_RANK       = 3'd0,
      CSR_INPUT_RANK        = 3'd1,
      CSR_OUTPUT_DIMS_INNER = 3'd2,
      CSR_OUTPUT_DIMS_OUTER = 3'd3,
      CSR_INPUT_DIMS_INNER  = 3'd4,
      CSR_INPUT_DIMS_OUTER  = 3'd5,
      CSR_ELEMENT_BYTES     = 3'd6,
      CSR_BASE_ADDRESS      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RANK_W-1:0] active_dims;
      logic [EB_W-1:0]   element_bytes;
      logic [ADDR_W-1:0] base_address;
   } cfg_type;

endpackage

// ===== rtl/broadcast_source_address_generator.sv =====
// Broadcast source address generator, top level.
// Each request transfer carries a flat output element index. The block splits
// it into coordinates over the configured output shape, clamps each to the
// source shape for broadcasting, weights them by the running source strides
// and returns the element offset and base + offset * element_bytes.
// One request can be taken every cycle while req_stall is low; the pipeline
// holds one item per stage. Each dimension takes eight division stages of four
// quotient bits and one weighting stage, plus the queue and address stages.
// After reset and after any csr write, req_stall stays high while the stride
// products are rebuilt by one shared multiplier.
// When rsp_stall is high while a result waits in the output register, the
// whole pipeline holds; the four-entry input queue keeps accepting until it
// fills, then req_stall rises. Depends on bsag_pkg, bsag_cfg, bsag_queue and
// bsag_back. Registers are written with csr_we, csr_index and csr_wdata; the
// user must write them only while idle, the block itself does not enforce it.
module broadcast_source_address_generator #(
   parameter int MAX_RANK = bsag_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS = bsag_pkg::DEF_DIM_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  bsag_pkg::csr_index_type     csr_index,
   input  logic [bsag_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bsag_pkg::IDX_W-1:0]  req_linear_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bsag_pkg::IDX_W-1:0]  rsp_element_offset,
   output logic [bsag_pkg::ADDR_W-1:0] rsp_byte_address
);
   import bsag_pkg::*;

   cfg_type             cfg;
   logic                busy, full, push, pop, head_valid;
   logic [IDX_W-1:0]    head_data;
   logic [DIM_BITS-1:0] out_div [MAX_RANK];
   logic [DIM_BITS-1:0] in_lim  [MAX_RANK];
   logic [IDX_W-1:0]    weight  [MAX_RANK];

   assign req_stall = full || busy;
   assign push      = req_valid && !req_stall;

   bsag_cfg #(.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS)) u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .busy, .cfg, .out_div, .in_lim, .weight
   );

   bsag_queue u_queue (
      .clock, .reset, .push, .push_data(req_linear_index), .full,
      .pop, .head_valid, .head_data
   );

   bsag_back #(.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS)) u_back (
      .clock, .reset, .cfg, .out_div, .in_lim, .weight,
      .head_valid, .head_data, .pop,
      .rsp_valid, .rsp_stall, .rsp_element_offset, .rsp_byte_address
   );

endmodule

// ===== rtl/bsag_cfg.sv =====
// Configuration registers, per-dimension divisors and clamp limits, and the
// sequencer that builds the running weight products. Depends on bsag_pkg.
module bsag_cfg #(
   parameter int MAX_RANK = bsag_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS = bsag_pkg::DEF_DIM_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  bsag_pkg::csr_index_type       csr_index,
   input  logic [bsag_pkg::CFG_W-1:0]    csr_wdata,
   output logic                          busy,
   output bsag_pkg::cfg_type             cfg,
   output logic [DIM_BITS-1:0]           out_div [MAX_RANK],
   output logic [DIM_BITS-1:0]           in_lim  [MAX_RANK],
   output logic [bsag_pkg::IDX_W-1:0]    weight  [MAX_RANK]
);
   import bsag_pkg::*;

   localparam int CW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

   logic [RANK_W-1:0] orank_ff, irank_ff;
   logic [CFG_W-1:0]  odi_ff, odo_ff, idi_ff, ido_ff;
   logic [EB_W-1:0]   eb_ff;
   logic [ADDR_W-1:0] base_ff;
   logic              busy_ff;
   logic [CW-1:0]     cnt_ff;
   logic [IDX_W-1:0]  weight_ff [MAX_RANK];
   logic [DIM_BITS-1:0] in_dim [MAX_RANK];
   logic [RANK_W-1:0] orank_eff, irank_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orank_ff <= RANK_W'(1);
         irank_ff <= RANK_W'(1);
         odi_ff   <= '0;
         odo_ff   <= '0;
         idi_ff   <= '0;
         ido_ff   <= '0;
         eb_ff    <= EB_W'(4);
         base_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUTPUT_RANK:       orank_ff <= csr_wdata[RANK_W-1:0];
            CSR_INPUT_RANK:        irank_ff <= csr_wdata[RANK_W-1:0];
            CSR_OUTPUT_DIMS_INNER: odi_ff   <= csr_wdata;
            CSR_OUTPUT_DIMS_OUTER: odo_ff   <= csr_wdata;
            CSR_INPUT_DIMS_INNER:  idi_ff   <= csr_wdata;
            CSR_INPUT_DIMS_OUTER:  ido_ff   <= csr_wdata;
            CSR_ELEMENT_BYTES:     eb_ff    <= csr_wdata[EB_W-1:0];
            CSR_BASE_ADDRESS:      base_ff  <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Dimension slots; a slot programmed as zero acts as a size-one dimension.
   for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
      logic [DIM_BITS-1:0] od, id;
      always_comb begin
         od = (d < SLOTS_PER_W) ? odi_ff[(d % SLOTS_PER_W)*SLOT_BITS +: DIM_BITS]
                                : odo_ff[(d % SLOTS_PER_W)*SLOT_BITS +: DIM_BITS];
         id = (d < SLOTS_PER_W) ? idi_ff[(d % SLOTS_PER_W)*SLOT_BITS +: DIM_BITS]
                                : ido_ff[(d % SLOTS_PER_W)*SLOT_BITS +: DIM_BITS];
         out_div[d] = (od == '0) ? DIM_BITS'(1) : od;
         in_dim[d]  = (id == '0) ? DIM_BITS'(1) : id;
         in_lim[d]  = in_dim[d] - DIM_BITS'(1);
      end
   end

   always_comb begin
      orank_eff = (orank_ff > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : orank_ff;
      irank_eff = (irank_ff > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : irank_ff;
      cfg.active_dims   = (orank_eff < irank_eff) ? orank_eff : irank_eff;
      cfg.element_bytes = eb_ff;
      cfg.base_address  = base_ff;
   end

   // After reset and after every register write the weights are rebuilt one
   // product per cycle; input transfers are held off until that finishes.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         busy_ff      <= 1'b1;
         cnt_ff       <= '0;
         weight_ff[0] <= IDX_W'(1);
      end else if (busy_ff) begin
         if (cnt_ff == CW'(MAX_RANK-1)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + CW'(1);
            weight_ff[cnt_ff + CW'(1)] <= IDX_W'(weight_ff[cnt_ff] * in_dim[cnt_ff]);
         end
      end
   end

   always_comb begin
      weight[0] = IDX_W'(1);
      for (int d = 1; d < MAX_RANK; d++) begin
         weight[d] = weight_ff[d];
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/bsag_queue.sv =====
// Short input queue that parts the request side from the address pipeline.
// Depends on bsag_pkg for the queue depth and index width.
module bsag_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [bsag_pkg::IDX_W-1:0] push_data,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output logic [bsag_pkg::IDX_W-1:0] head_data
);
   import bsag_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [IDX_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [NW-1:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_comb begin
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PW'(1);
         if (pop)  rd_ff <= rd_ff + PW'(1);
         count_ff <= count_in;
      end
   end

   assign full       = (count_ff == NW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid)) else $error("queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + NW'(1)))
      else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== rtl/bsag_back.sv =====
// Address pipeline: per dimension a staged long division, then clamp and
// weighting, then the byte address. Depends on bsag_pkg.
module bsag_back #(
   parameter int MAX_RANK = bsag_pkg::DEF_MAX_RANK,
   parameter int DIM_BITS = bsag_pkg::DEF_DIM_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bsag_pkg::cfg_type           cfg,
   input  logic [DIM_BITS-1:0]         out_div [MAX_RANK],
   input  logic [DIM_BITS-1:0]         in_lim  [MAX_RANK],
   input  logic [bsag_pkg::IDX_W-1:0]  weight  [MAX_RANK],
   input  logic                        head_valid,
   input  logic [bsag_pkg::IDX_W-1:0]  head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bsag_pkg::IDX_W-1:0]  rsp_element_offset,
   output logic [bsag_pkg::ADDR_W-1:0] rsp_byte_address
);
   import bsag_pkg::*;

   localparam int SUBS  = IDX_W / DIV_STEPS + 1;
   localparam int TOTAL = MAX_RANK * SUBS;

   typedef struct packed {
      logic                v;
      logic [IDX_W-1:0]    quo;
      logic [DIM_BITS-1:0] rem;
      logic [IDX_W-1:0]    ofs;
   } stage_type;

   stage_type         pipe_ff [TOTAL];
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_ofs_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              adv;

   // The whole pipeline moves together whenever the output register is free.
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   for (genvar s = 0; s < TOTAL; s++) begin : g_stage
      localparam int D   = s / SUBS;
      localparam int SUB = s % SUBS;
      stage_type src, stage_in;

      if (s == 0) begin : g_src0
         always_comb begin
            src.v   = head_valid;
            src.quo = head_data;
            src.rem = '0;
            src.ofs = '0;
         end
      end else begin : g_srcn
         always_comb src = pipe_ff[s-1];
      end

      if (SUB < SUBS - 1) begin : g_div
         // Restoring division, a few quotient bits per stage.
         always_comb begin
            logic [DIM_BITS:0] t;
            stage_in = src;
            for (int k = 0; k < DIV_STEPS; k++) begin
               t = {stage_in.rem, stage_in.quo[IDX_W-1]};
               stage_in.quo = {stage_in.quo[IDX_W-2:0], 1'b0};
               if (t >= {1'b0, out_div[D]}) begin
                  t = t - {1'b0, out_div[D]};
                  stage_in.quo[0] = 1'b1;
               end
               stage_in.rem = t[DIM_BITS-1:0];
            end
         end
      end else begin : g_wt
         // Clamp for broadcasting and add the weighted coordinate; the
         // remainder restarts at zero for the next dimension.
         always_comb begin
            logic [DIM_BITS-1:0] c;
            c = (src.rem > in_lim[D]) ? in_lim[D] : src.rem;
            stage_in = src;
            stage_in.rem = '0;
            if (RANK_W'(D) < cfg.active_dims) begin
               stage_in.ofs = src.ofs + IDX_W'(c * weight[D]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[s].v <= 1'b0;
         end else if (adv) begin
            pipe_ff[s] <= stage_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pipe_ff[TOTAL-1].v;
         rsp_ofs_ff   <= pipe_ff[TOTAL-1].ofs;
         rsp_addr_ff  <= cfg.base_address
                         + ADDR_W'(ADDR_W'(pipe_ff[TOTAL-1].ofs) * ADDR_W'(cfg.element_bytes));
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_element_offset = rsp_ofs_ff;
   assign rsp_byte_address   = rsp_addr_ff;

`ifndef SYNTHESIS
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> pipe_ff[0].v) else $error("popped item did not enter the pipeline");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> pipe_ff[0] === $past(pipe_ff[0]))
      else $error("pipeline moved while the output was held");
   a_no_pop_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop) else $error("pop while output held");
`endif

endmodule

// ===== tb/sv/tb_broadcast_source_address_generator.sv =====
// Testbench for the broadcast source address generator.
// Depends on bsag_pkg and the broadcast_source_address_generator top level.
module tb_broadcast_source_address_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import bsag_pkg::*;

   localparam int LATENCY   = DEF_MAX_RANK * 9 + 1;
   localparam int WDOG_MAX  = 20000;

   typedef struct {
      logic [IDX_W-1:0]  element_offset;
      logic [ADDR_W-1:0] byte_address;
   } addr_result_type;

   class address_scoreboard;
      logic [3:0]        out_rank, in_rank;
      logic [63:0]       out_dims_lo, out_dims_hi, in_dims_lo, in_dims_hi;
      logic [4:0]        elem_bytes;
      logic [ADDR_W-1:0] base;
      addr_result_type   pending[$];
      int                errors;

      function void reset_regs();
         out_rank = 1; in_rank = 1;
         out_dims_lo = 0; out_dims_hi = 0; in_dims_lo = 0; in_dims_hi = 0;
         elem_bytes = 4; base = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] v);
         case (idx)
            CSR_OUTPUT_RANK:       out_rank = v[3:0];
            CSR_INPUT_RANK:        in_rank = v[3:0];
            CSR_OUTPUT_DIMS_INNER: out_dims_lo = v;
            CSR_OUTPUT_DIMS_OUTER: out_dims_hi = v;
            CSR_INPUT_DIMS_INNER:  in_dims_lo = v;
            CSR_INPUT_DIMS_OUTER:  in_dims_hi = v;
            CSR_ELEMENT_BYTES:     elem_bytes = v[4:0];
            CSR_BASE_ADDRESS:      base = v[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] dim_size(logic [63:0] lo, logic [63:0] hi, int d);
         logic [63:0] w;
         logic [15:0] s;
         w = (d < 4) ? lo : hi;
         s = w[(d % 4) * 16 +: 16];
         return (s == 0) ? 32'd1 : {16'd0, s};
      endfunction

      // Splits the index over the output shape, clamps to the source shape.
      function void note_request(logic [IDX_W-1:0] lin);
         logic [31:0] k, od, id, c, off, stride;
         logic [31:0] coord[8];
         logic [63:0] prod;
         int orank, irank, n;
         addr_result_type r;
         orank = (out_rank > 8) ? 8 : out_rank;
         irank = (in_rank > 8) ? 8 : in_rank;
         n = (orank < irank) ? orank : irank;
         k = lin; off = 0; stride = 1;
         for (int d = 0; d < orank; d++) begin
            od = dim_size(out_dims_lo, out_dims_hi, d);
            coord[d] = k % od;
            k = k / od;
         end
         for (int d = 0; d < n; d++) begin
            id = dim_size(in_dims_lo, in_dims_hi, d);
            c = (coord[d] > id - 1) ? id - 1 : coord[d];
            off = off + c * stride;
            stride = stride * id;
         end
         prod = {32'd0, off} * {59'd0, elem_bytes};
         r.element_offset = off;
         r.byte_address = base + prod[ADDR_W-1:0];
         pending.push_back(r);
      endfunction

      function void check_response(logic [IDX_W-1:0] off, logic [ADDR_W-1:0] addr);
         addr_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: offset %0h address %0h", off, addr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (off !== e.element_offset) begin
            $error("element_offset expected %0h actual %0h", e.element_offset, off);
            errors++;
         end
         if (addr !== e.byte_address) begin
            $error("byte_address expected %0h actual %0h", e.byte_address, addr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_we = 0;
   csr_index_type csr_index = CSR_OUTPUT_RANK;
   logic [CFG_W-1:0] csr_wdata = 0;
   logic req_valid = 0, req_stall;
   logic [IDX_W-1:0] req_linear_index = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [IDX_W-1:0] rsp_element_offset;
   logic [ADDR_W-1:0] rsp_byte_address;

   address_scoreboard sb = new();
   int  idle_pct = 21;     // shared by both sides; zero during the calm stretch
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;

   broadcast_source_address_generator DUT (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_linear_index);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_element_offset, rsp_byte_address);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver side: random stall unless a long hold-off is requested.
   always @(negedge clock)
      rsp_stall <= hold_rsp || ($urandom_range(99) < idle_pct);

   task automatic write_csr(csr_index_type idx, logic [63:0] v);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Holds one request until it transfers; valid stays up for the next one
   // unless the sender idles or drains.
   task automatic send_index(logic [IDX_W-1:0] lin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_linear_index <= lin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [63:0] rand_dims(int maxd);
      logic [63:0] v;
      for (int i = 0; i < 4; i++)
         v[i*16 +: 16] = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, maxd));
      return v;
   endfunction

   task automatic random_shape();
      write_csr(CSR_OUTPUT_RANK, $urandom_range(15));
      write_csr(CSR_INPUT_RANK, $urandom_range(15));
      write_csr(CSR_OUTPUT_DIMS_INNER, rand_dims(9));
      write_csr(CSR_OUTPUT_DIMS_OUTER, rand_dims(9));
      // Size-one source dims make broadcasting common.
      write_csr(CSR_INPUT_DIMS_INNER, rand_dims($urandom_range(1) ? 1 : 12));
      write_csr(CSR_INPUT_DIMS_OUTER, rand_dims(12));
      write_csr(CSR_ELEMENT_BYTES, $urandom_range(31));
      write_csr(CSR_BASE_ADDRESS, {$urandom, $urandom});
   endtask

   function automatic logic [31:0] rand_index();
      case ($urandom_range(3))
         0: return 32'($urandom_range(4000));
         1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      sb.reset_regs();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (DEF_MAX_RANK + 2) @(negedge clock);

      // Directed: reset shape, then extremes and broadcast cases.
      send_index(32'd0);
      send_index(32'hFFFF_FFFF);
      drain();
      write_csr(CSR_OUTPUT_RANK, 4);
      write_csr(CSR_INPUT_RANK, 4);
      write_csr(CSR_OUTPUT_DIMS_INNER, {16'd5, 16'd4, 16'd3, 16'd2});
      write_csr(CSR_INPUT_DIMS_INNER, {16'd5, 16'd1, 16'd3, 16'd1});
      write_csr(CSR_ELEMENT_BYTES, 16);
      write_csr(CSR_BASE_ADDRESS, 48'hFFFF_FFFF_FFF0);
      for (int i = 0; i < 8; i++) send_index(i * 7);
      send_index(32'hFFFF_FFFF);
      drain();
      // Full rank, widest dims, overflowing offset, zero element size.
      write_csr(CSR_OUTPUT_RANK, 15);
      write_csr(CSR_INPUT_RANK, 8);
      write_csr(CSR_OUTPUT_DIMS_INNER, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_OUTPUT_DIMS_OUTER, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_INPUT_DIMS_INNER, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_INPUT_DIMS_OUTER, 64'hFFFF_FFFF_0000_FFFF);
      write_csr(CSR_ELEMENT_BYTES, 0);
      send_index(32'hFFFF_FFFF);
      send_index(32'h8000_0001);
      drain();
      write_csr(CSR_OUTPUT_RANK, 0);
      write_csr(CSR_ELEMENT_BYTES, 31);
      send_index(32'h1234_5678);
      drain();
      write_csr(CSR_OUTPUT_RANK, 3);
      write_csr(CSR_INPUT_RANK, 0);
      send_index(32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         random_shape();
         if (ph == 3) begin
            // Long receiver hold-off with more requests than the block can
            // hold, so the pipeline and queue fill and requests stall.
            fork
               begin hold_rsp = 1; repeat (300) @(negedge clock); hold_rsp = 0; end
               for (int i = 0; i < 100; i++) send_index(rand_index());
            join
         end else begin
            if (ph == 6) idle_pct = 0;
            for (int i = 0; i < 36; i++) send_index(rand_index());
            idle_pct = 21;
         end
         // The sender pauses until every expected result has come.
         drain();
      end

      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
